### rtl/core/hrp_pkg.sv
// Shared types, codes and match tables for the HTTP request head parser.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package hrp_pkg;

    // Depth of the queue between the front and back halves
    localparam int QUEUE_DEPTH = 2;

    localparam int NUM_METHODS  = 4;
    localparam int NUM_VERSIONS = 3;

    // Field tags carried on each result
    localparam logic [2:0] TAG_METHOD  = 3'd0;
    localparam logic [2:0] TAG_URI     = 3'd1;
    localparam logic [2:0] TAG_VERSION = 3'd2;
    localparam logic [2:0] TAG_HEADER  = 3'd3;
    localparam logic [2:0] TAG_DELIM   = 3'd4;
    localparam logic [2:0] TAG_BODY    = 3'd5;
    localparam logic [2:0] TAG_DISCARD = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_METHOD    = 2'd1;
    localparam logic [1:0] ERR_VERSION   = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    // Line end tracker codes
    localparam logic [1:0] LE_IN_LINE  = 2'd0;
    localparam logic [1:0] LE_CR       = 2'd1;
    localparam logic [1:0] LE_START    = 2'd2;
    localparam logic [1:0] LE_START_CR = 2'd3;

    // Special characters
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [3:0] POS_MAX = 4'd15;

    // Parser phases
    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADER  = 3'd3,
        PH_BODY    = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    // Input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } hrp_in_t;

    // Result transaction
    typedef struct packed {
        logic [2:0] field_tag;
        logic [1:0] error_code;
        logic [1:0] method_id;
        logic [1:0] version_id;
        logic       head_done;
        logic       last_out;
    } hrp_out_t;

    // Classified byte passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
        logic       is_sp;
        logic       is_cr;
        logic       is_lf;
    } hrp_item_t;

    // Token text, zero padded to eight characters
    localparam logic [7:0] METHOD_TEXT [NUM_METHODS][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00}
    };
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{4'd3, 4'd4, 4'd3, 4'd6};

    localparam logic [7:0] VERSION_TEXT [NUM_VERSIONS][8] = '{
        '{"H", "T", "T", "P", "/", "1", ".", "0"},
        '{"H", "T", "T", "P", "/", "1", ".", "1"},
        '{"H", "T", "T", "P", "/", "2", 8'h00, 8'h00}
    };
    localparam logic [3:0] VERSION_LEN [NUM_VERSIONS] = '{4'd8, 4'd8, 4'd6};

    // Drop every method that the byte at this position rules out
    function automatic logic [NUM_METHODS-1:0] method_narrow(
        input logic [NUM_METHODS-1:0] mask,
        input logic [3:0]             pos,
        input logic [7:0]             ch
    );
        logic [NUM_METHODS-1:0] res;
        res = mask;
        for (int k = 0; k < NUM_METHODS; k++) begin
            if (pos >= METHOD_LEN[k] || METHOD_TEXT[k][pos[2:0]] != ch)
                res[k] = 1'b0;
        end
        return res;
    endfunction

    // Drop every version that the byte at this position rules out
    function automatic logic [NUM_VERSIONS-1:0] version_narrow(
        input logic [NUM_VERSIONS-1:0] mask,
        input logic [3:0]              pos,
        input logic [7:0]              ch
    );
        logic [NUM_VERSIONS-1:0] res;
        res = mask;
        for (int k = 0; k < NUM_VERSIONS; k++) begin
            if (pos >= VERSION_LEN[k] || VERSION_TEXT[k][pos[2:0]] != ch)
                res[k] = 1'b0;
        end
        return res;
    endfunction

    // {hit, index} of the lowest method matching the whole token
    function automatic logic [2:0] method_accept(
        input logic [NUM_METHODS-1:0] mask,
        input logic [3:0]             pos
    );
        logic [2:0] res;
        res = '0;
        for (int k = NUM_METHODS - 1; k >= 0; k--) begin
            if (mask[k] && pos == METHOD_LEN[k])
                res = {1'b1, 2'(k)};
        end
        return res;
    endfunction

    // {hit, index} of the lowest version matching the whole token
    function automatic logic [2:0] version_accept(
        input logic [NUM_VERSIONS-1:0] mask,
        input logic [3:0]              pos
    );
        logic [2:0] res;
        res = '0;
        for (int k = NUM_VERSIONS - 1; k >= 0; k--) begin
            if (mask[k] && pos == VERSION_LEN[k])
                res = {1'b1, 2'(k)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/http_request_head_parser.sv
// Top level of the HTTP request head parser: front, queue and back halves.
// Depends on hrp_pkg, hrp_front, hrp_queue and hrp_back.
//
// Usage:
//   Request bytes enter on the req channel (req_valid/req_ready/req_data),
//   one byte per transaction, with end_of_buffer set on the last byte of a
//   request buffer. Each byte yields exactly one result transaction on the
//   res channel (res_valid/res_ready/res_data): its field tag, the latched
//   error code, the matched method and version, head_done on the LF of the
//   blank line, and last_out echoing end_of_buffer.
//   An accepted byte passes through the front register, then the queue,
//   then the result register before its result appears on the res channel.
//   Throughput: one byte per cycle while res_ready stays high; the back half
//   computes its phase update and candidate-mask narrowing combinationally.
//   Reset (rst_n low) empties the front stage, queue and result register and
//   puts the parser in the method phase. After every final byte the parser
//   rearms to the same state on its own.
//   When the receiver stalls, the result register holds, the queue fills
//   (QUEUE_DEPTH entries) and then req_ready drops once the front stage is
//   also full; no transaction is lost.
`default_nettype none

module http_request_head_parser #(
    parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire hrp_pkg::hrp_in_t  req_data,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output hrp_pkg::hrp_out_t      res_data
);

    logic               f_valid;
    logic               f_ready;
    hrp_pkg::hrp_item_t f_item;
    logic               q_valid;
    logic               q_ready;
    hrp_pkg::hrp_item_t q_item;

    // Byte intake and classification
    hrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // Decoupling queue
    hrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Parser state machine and result register
    hrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

`default_nettype wire

### rtl/core/hrp_front.sv
// Front half of the parser: takes input transactions and classifies each byte.
// Depends on hrp_pkg.
`default_nettype none

module hrp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire hrp_pkg::hrp_in_t req_data,
    output logic                  item_valid,
    input  wire logic             item_ready,
    output hrp_pkg::hrp_item_t    item
);

    logic               valid_reg;
    logic               valid_next;
    hrp_pkg::hrp_item_t item_reg;
    hrp_pkg::hrp_item_t item_next;
    logic               take;

    // Stage is free when empty or when its item moves on this cycle
    assign req_ready = !valid_reg || item_ready;
    assign take      = req_valid && req_ready;

    // Byte classification
    always_comb
    begin
        item_next.data_byte     = req_data.data_byte;
        item_next.end_of_buffer = req_data.end_of_buffer;
        item_next.is_sp         = (req_data.data_byte == hrp_pkg::CH_SP);
        item_next.is_cr         = (req_data.data_byte == hrp_pkg::CH_CR);
        item_next.is_lf         = (req_data.data_byte == hrp_pkg::CH_LF);
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### rtl/core/hrp_queue.sv
// Short queue between the front and back halves of the parser.
// Depends on hrp_pkg for the item type.
`default_nettype none

module hrp_queue #(
    parameter int DEPTH = hrp_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire hrp_pkg::hrp_item_t push_item,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output hrp_pkg::hrp_item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrp_pkg::hrp_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/core/hrp_back.sv
// Back half of the parser: phase machine, token matching and result register.
// Depends on hrp_pkg for types, codes and match tables.
`default_nettype none

module hrp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire hrp_pkg::hrp_item_t item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output hrp_pkg::hrp_out_t       res_data
);

    hrp_pkg::phase_t                    phase_reg;
    hrp_pkg::phase_t                    phase_next;
    logic [3:0]                         pos_reg;
    logic [3:0]                         pos_next;
    logic [hrp_pkg::NUM_METHODS-1:0]    mcand_reg;
    logic [hrp_pkg::NUM_METHODS-1:0]    mcand_next;
    logic [hrp_pkg::NUM_VERSIONS-1:0]   vcand_reg;
    logic [hrp_pkg::NUM_VERSIONS-1:0]   vcand_next;
    logic [1:0]                         line_end_reg;
    logic [1:0]                         line_end_next;
    logic [1:0]                         err_reg;
    logic [1:0]                         err_next;
    logic [1:0]                         method_reg;
    logic [1:0]                         method_next;
    logic [1:0]                         version_reg;
    logic [1:0]                         version_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    hrp_pkg::hrp_out_t                  out_reg;
    hrp_pkg::hrp_out_t                  out_next;

    logic                               step;
    logic [2:0]                         m_hit;
    logic [2:0]                         v_hit;
    logic [3:0]                         pos_bump;
    logic                               lf_ends_version;
    logic [2:0]                         tag;
    logic                               done;
    logic [1:0]                         err_upd;

    // Result register frees up when empty or when taken this cycle
    assign item_ready = !out_valid_reg || res_ready;
    assign step       = item_valid && item_ready;

    assign m_hit           = hrp_pkg::method_accept(mcand_reg, pos_reg);
    assign v_hit           = hrp_pkg::version_accept(vcand_reg, pos_reg);
    assign pos_bump        = (pos_reg == hrp_pkg::POS_MAX) ? pos_reg : pos_reg + 4'd1;
    assign lf_ends_version = (line_end_reg == hrp_pkg::LE_CR) && item.is_lf;

    // Phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            hrp_pkg::PH_METHOD:
            begin
                if (item.is_sp)
                    phase_next = m_hit[2] ? hrp_pkg::PH_URI : hrp_pkg::PH_DISCARD;
            end
            hrp_pkg::PH_URI:
            begin
                if (item.is_sp)
                    phase_next = hrp_pkg::PH_VERSION;
            end
            hrp_pkg::PH_VERSION:
            begin
                if (lf_ends_version)
                    phase_next = v_hit[2] ? hrp_pkg::PH_HEADER : hrp_pkg::PH_DISCARD;
            end
            hrp_pkg::PH_HEADER:
            begin
                if (item.is_lf && line_end_reg == hrp_pkg::LE_START_CR)
                    phase_next = hrp_pkg::PH_BODY;
            end
            hrp_pkg::PH_BODY:    phase_next = hrp_pkg::PH_BODY;
            hrp_pkg::PH_DISCARD: phase_next = hrp_pkg::PH_DISCARD;
            default:             phase_next = phase_reg;
        endcase
    end

    // Tagging, matching and token bookkeeping
    always_comb
    begin
        tag           = hrp_pkg::TAG_DISCARD;
        done          = 1'b0;
        pos_next      = pos_reg;
        mcand_next    = mcand_reg;
        vcand_next    = vcand_reg;
        line_end_next = line_end_reg;
        err_upd       = err_reg;
        method_next   = method_reg;
        version_next  = version_reg;
        unique case (phase_reg)
            hrp_pkg::PH_METHOD:
            begin
                if (item.is_sp)
                begin
                    if (m_hit[2])
                    begin
                        method_next = m_hit[1:0];
                        tag         = hrp_pkg::TAG_DELIM;
                    end
                    else
                    begin
                        err_upd = hrp_pkg::ERR_METHOD;
                    end
                    pos_next = '0;
                end
                else
                begin
                    mcand_next = hrp_pkg::method_narrow(mcand_reg, pos_reg, item.data_byte);
                    pos_next   = pos_bump;
                    tag        = hrp_pkg::TAG_METHOD;
                end
            end
            hrp_pkg::PH_URI:
            begin
                if (item.is_sp)
                begin
                    pos_next      = '0;
                    vcand_next    = '1;
                    line_end_next = hrp_pkg::LE_IN_LINE;
                    tag           = hrp_pkg::TAG_DELIM;
                end
                else
                begin
                    tag = hrp_pkg::TAG_URI;
                end
            end
            hrp_pkg::PH_VERSION:
            begin
                if (lf_ends_version)
                begin
                    if (v_hit[2])
                    begin
                        version_next  = v_hit[1:0];
                        line_end_next = hrp_pkg::LE_START;
                        tag           = hrp_pkg::TAG_DELIM;
                    end
                    else
                    begin
                        err_upd       = hrp_pkg::ERR_VERSION;
                        line_end_next = hrp_pkg::LE_IN_LINE;
                    end
                    pos_next = '0;
                end
                else if (item.is_cr)
                begin
                    // a CR not followed by LF poisons the token
                    if (line_end_reg == hrp_pkg::LE_CR)
                        vcand_next = '0;
                    line_end_next = hrp_pkg::LE_CR;
                    tag           = hrp_pkg::TAG_DELIM;
                end
                else
                begin
                    vcand_next = hrp_pkg::version_narrow(
                        (line_end_reg == hrp_pkg::LE_CR) ? '0 : vcand_reg,
                        pos_reg, item.data_byte);
                    pos_next      = pos_bump;
                    line_end_next = hrp_pkg::LE_IN_LINE;
                    tag           = hrp_pkg::TAG_VERSION;
                end
            end
            hrp_pkg::PH_HEADER:
            begin
                if (item.is_cr)
                begin
                    line_end_next = (line_end_reg == hrp_pkg::LE_START) ?
                                    hrp_pkg::LE_START_CR : hrp_pkg::LE_CR;
                    tag = hrp_pkg::TAG_DELIM;
                end
                else if (item.is_lf && line_end_reg == hrp_pkg::LE_START_CR)
                begin
                    line_end_next = hrp_pkg::LE_IN_LINE;
                    done          = 1'b1;
                    tag           = hrp_pkg::TAG_DELIM;
                end
                else if (item.is_lf && line_end_reg == hrp_pkg::LE_CR)
                begin
                    line_end_next = hrp_pkg::LE_START;
                    tag           = hrp_pkg::TAG_DELIM;
                end
                else
                begin
                    line_end_next = hrp_pkg::LE_IN_LINE;
                    tag           = hrp_pkg::TAG_HEADER;
                end
            end
            hrp_pkg::PH_BODY:    tag = hrp_pkg::TAG_BODY;
            hrp_pkg::PH_DISCARD: tag = hrp_pkg::TAG_DISCARD;
            default:             tag = hrp_pkg::TAG_DISCARD;
        endcase
    end

    // Truncation check on the final byte
    always_comb
    begin
        err_next = err_upd;
        if (item.end_of_buffer && err_upd == hrp_pkg::ERR_NONE &&
            phase_next != hrp_pkg::PH_BODY)
            err_next = hrp_pkg::ERR_TRUNCATED;
    end

    // Result fields
    always_comb
    begin
        out_next.field_tag  = tag;
        out_next.error_code = err_next;
        out_next.method_id  = method_next;
        out_next.version_id = version_next;
        out_next.head_done  = done;
        out_next.last_out   = item.end_of_buffer;
    end

    always_comb
    begin
        if (step)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Parser state; the final byte rearms everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hrp_pkg::PH_METHOD;
            pos_reg       <= '0;
            mcand_reg     <= '1;
            vcand_reg     <= '1;
            line_end_reg  <= hrp_pkg::LE_IN_LINE;
            err_reg       <= hrp_pkg::ERR_NONE;
            method_reg    <= '0;
            version_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                if (item.end_of_buffer)
                begin
                    phase_reg    <= hrp_pkg::PH_METHOD;
                    pos_reg      <= '0;
                    mcand_reg    <= '1;
                    vcand_reg    <= '1;
                    line_end_reg <= hrp_pkg::LE_IN_LINE;
                    err_reg      <= hrp_pkg::ERR_NONE;
                    method_reg   <= '0;
                    version_reg  <= '0;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    pos_reg      <= pos_next;
                    mcand_reg    <= mcand_next;
                    vcand_reg    <= vcand_next;
                    line_end_reg <= line_end_next;
                    err_reg      <= err_next;
                    method_reg   <= method_next;
                    version_reg  <= version_next;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

`default_nettype wire

### rtl/core/hrp_checker.sv
// Port-level checks for the HTTP request head parser, bound to the top level.
// Depends on hrp_pkg and http_request_head_parser.
`default_nettype none

module hrp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire hrp_pkg::hrp_in_t  req_data,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire hrp_pkg::hrp_out_t res_data
);

    // A waiting request transaction holds its payload
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_data))
        else $error("request changed while waiting");

    // A stalled result transaction holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // End of headers is a clean delimiter
    a_done_tag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.head_done |->
            res_data.field_tag == hrp_pkg::TAG_DELIM &&
            res_data.error_code == hrp_pkg::ERR_NONE)
        else $error("head_done on a non-delimiter or with an error");

    // Discarded bytes only follow a method or version error
    a_discard_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.field_tag == hrp_pkg::TAG_DISCARD |->
            res_data.error_code == hrp_pkg::ERR_METHOD ||
            res_data.error_code == hrp_pkg::ERR_VERSION)
        else $error("discarded byte without a parse error");

    // Body bytes never carry an error
    a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.field_tag == hrp_pkg::TAG_BODY |->
            res_data.error_code == hrp_pkg::ERR_NONE &&
            !res_data.head_done)
        else $error("body byte with error or head_done");

endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire
